@@ rtl/vkvs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkvs_pkg
// Shared constants, codes and types of the versioned key/value store.
// ----------------------------------------------------------------------------
package vkvs_pkg;

   localparam int NUM_KEYS_DEF        = 16;
   localparam int ENTRIES_PER_KEY_DEF = 64;

   // request kinds
   localparam logic TYPE_STORE = 1'b0;
   localparam logic TYPE_FETCH = 1'b1;

   // result status codes
   localparam logic [2:0] ST_STORED = 3'd0;
   localparam logic [2:0] ST_HIT    = 3'd1;
   localparam logic [2:0] ST_MISS   = 3'd2;
   localparam logic [2:0] ST_FULL   = 3'd3;
   localparam logic [2:0] ST_ORDER  = 3'd4;

   // classified command handed from front to back
   typedef struct packed {
      logic        fetch;   // search the history
      logic        wr;      // append the pair to the history
      logic [2:0]  status;  // final status of a store
      logic [31:0] tstamp;
      logic [31:0] value;
   } cmd_type;

endpackage

@@ rtl/vkvs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkvs_req_if / vkvs_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface vkvs_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] req_key;
   logic [31:0] req_value;
   logic [31:0] req_time;
   modport source (output valid, req_type, req_key, req_value, req_time, input ready);
   modport sink   (input valid, req_type, req_key, req_value, req_time, output ready);
endinterface

interface vkvs_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] result_value;
   logic [2:0]  status;
   modport source (output valid, found, result_value, status, input ready);
   modport sink   (input valid, found, result_value, status, output ready);
endinterface

@@ rtl/versioned_key_value_store.sv @@
`timescale 1ns / 1ps
// Order: a store passes the command queue and then the response register; a
//   retrieval alternates S_SRCH and S_CMP for each binary-search step, paced by the
//   one-read-port history memory with a registered read per search step.
// Throughput: one item at a time in the back part; a two-entry queue lets the
//   front take further requests meanwhile. Reset clears slot valid bits and
//   counts at once; key and history storage is left as is.
// ----------------------------------------------------------------------------
// versioned_key_value_store
// Key table with per-key timestamped histories and floor lookups.
// ----------------------------------------------------------------------------
module versioned_key_value_store #(
   parameter int NUM_KEYS        = vkvs_pkg::NUM_KEYS_DEF,
   parameter int ENTRIES_PER_KEY = vkvs_pkg::ENTRIES_PER_KEY_DEF
) (
   input logic        clock,
   input logic        reset,
   vkvs_req_if.sink   req_bus,
   vkvs_rsp_if.source rsp_bus
);

   localparam int SW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam int CW = $clog2(ENTRIES_PER_KEY + 1);
   localparam int QW = $bits(vkvs_pkg::cmd_type) + SW + CW;

   vkvs_pkg::cmd_type f_cmd, b_cmd;
   logic [SW-1:0]     f_slot, b_slot;
   logic [CW-1:0]     f_count, b_count;
   logic              q_push, q_pop, q_full, q_empty;
   logic [QW-1:0]     q_in, q_out;

   vkvs_front #(.NUM_KEYS(NUM_KEYS), .ENTRIES_PER_KEY(ENTRIES_PER_KEY)) u_front (
      .clock(clock), .reset(reset), .req_bus(req_bus), .q_full(q_full),
      .q_push(q_push), .q_cmd(f_cmd), .q_slot(f_slot), .q_count(f_count)
   );

   assign q_in = {f_cmd, f_slot, f_count};

   vkvs_fifo #(.WIDTH(QW)) u_fifo (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   assign {b_cmd, b_slot, b_count} = q_out;

   vkvs_back #(.NUM_KEYS(NUM_KEYS), .ENTRIES_PER_KEY(ENTRIES_PER_KEY)) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_pop(q_pop),
      .q_cmd(b_cmd), .q_slot(b_slot), .q_count(b_count), .rsp_bus(rsp_bus)
   );

   // no transfer into a full queue, no pop from an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("command pushed into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("command popped from empty queue");
   // found goes with hit status; otherwise the value is zero
   a_found_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.found == (rsp_bus.status == vkvs_pkg::ST_HIT)))
      else $error("found flag disagrees with status");
   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.found) |-> (rsp_bus.result_value == 32'd0))
      else $error("nonzero value without a hit");

endmodule

@@ rtl/vkvs_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkvs_fifo
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module vkvs_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // hold entry data
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/vkvs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkvs_front
// Key table: matches the key, allocates slots, decides store outcomes.
// ----------------------------------------------------------------------------
module vkvs_front #(
   parameter int NUM_KEYS        = vkvs_pkg::NUM_KEYS_DEF,
   parameter int ENTRIES_PER_KEY = vkvs_pkg::ENTRIES_PER_KEY_DEF,
   localparam int SW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
   localparam int CW = $clog2(ENTRIES_PER_KEY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   vkvs_req_if.sink          req_bus,
   input  logic              q_full,
   output logic              q_push,
   output vkvs_pkg::cmd_type q_cmd,
   output logic [SW-1:0]     q_slot,
   output logic [CW-1:0]     q_count
);

   logic [31:0]   key_ff   [NUM_KEYS];
   logic [31:0]   last_ff  [NUM_KEYS];
   logic [CW-1:0] count_ff [NUM_KEYS];
   logic [CW-1:0] count_in [NUM_KEYS];
   logic          valid_ff [NUM_KEYS];
   logic          valid_in [NUM_KEYS];

   logic          hit, has_free;
   logic [SW-1:0] hit_idx, free_idx;
   logic [CW-1:0] n;
   logic [31:0]   last_t;
   logic          upd;
   logic [SW-1:0] upd_idx;

   assign req_bus.ready = ~q_full;
   assign q_push        = req_bus.valid & ~q_full;

   // match key and find the lowest free slot
   always_comb begin
      hit      = 1'b0;
      has_free = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = NUM_KEYS - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == req_bus.req_key) begin
            hit     = 1'b1;
            hit_idx = SW'(i);
         end
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   assign n      = hit ? count_ff[hit_idx] : '0;
   assign last_t = last_ff[hit_idx];

   // classify the request
   always_comb begin
      q_cmd.fetch  = (req_bus.req_type == vkvs_pkg::TYPE_FETCH);
      q_cmd.wr     = 1'b0;
      q_cmd.status = vkvs_pkg::ST_STORED;
      q_cmd.tstamp = req_bus.req_time;
      q_cmd.value  = req_bus.req_value;
      q_slot       = hit ? hit_idx : free_idx;
      q_count      = n;
      upd          = 1'b0;
      upd_idx      = q_slot;
      if (req_bus.req_type == vkvs_pkg::TYPE_STORE) begin
         if (!hit && !has_free) begin
            q_cmd.status = vkvs_pkg::ST_FULL;
         end else if (hit && n != '0 && req_bus.req_time <= last_t) begin
            q_cmd.status = vkvs_pkg::ST_ORDER;
         end else if (n >= CW'(ENTRIES_PER_KEY)) begin
            q_cmd.status = vkvs_pkg::ST_FULL;
         end else begin
            q_cmd.wr = 1'b1;
            upd      = q_push;
         end
      end
   end

   // next valid bits and counts
   always_comb begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         valid_in[i] = valid_ff[i];
         count_in[i] = count_ff[i];
         if (upd && upd_idx == SW'(i)) begin
            valid_in[i] = 1'b1;
            count_in[i] = n + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            valid_ff[i] <= 1'b0;
            count_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
   end

   // record key and newest timestamp
   always_ff @(posedge clock) begin
      if (upd) begin
         key_ff[upd_idx]  <= req_bus.req_key;
         last_ff[upd_idx] <= req_bus.req_time;
      end
   end

endmodule

@@ rtl/vkvs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vkvs_back
// History memory: appends pairs and binary-searches a key's history.
// ----------------------------------------------------------------------------
module vkvs_back #(
   parameter int NUM_KEYS        = vkvs_pkg::NUM_KEYS_DEF,
   parameter int ENTRIES_PER_KEY = vkvs_pkg::ENTRIES_PER_KEY_DEF,
   localparam int SW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1,
   localparam int CW    = $clog2(ENTRIES_PER_KEY + 1),
   localparam int DEPTH = NUM_KEYS * ENTRIES_PER_KEY,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  vkvs_pkg::cmd_type q_cmd,
   input  logic [SW-1:0]     q_slot,
   input  logic [CW-1:0]     q_count,
   vkvs_rsp_if.source        rsp_bus
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SRCH = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;

   logic [31:0] mem_t [DEPTH];
   logic [31:0] mem_v [DEPTH];

   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [31:0]   qt_ff, qt_in, best_ff, best_in;
   logic          hit_ff, hit_in;
   logic [31:0]   rd_t_ff, rd_v_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;

   logic          out_free, we;
   logic [CW-1:0] mid;
   logic [AW-1:0] addr;

   assign out_free = ~rsp_valid_ff | rsp_bus.ready;
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);

   // pick the memory address: append slot in idle, midpoint while searching
   always_comb begin
      if (state_ff == S_IDLE) begin
         addr = AW'(32'(q_slot) * ENTRIES_PER_KEY + 32'(q_count));
      end else begin
         addr = AW'(32'(slot_ff) * ENTRIES_PER_KEY + 32'(mid));
      end
   end

   // sequence the search
   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      qt_in         = qt_ff;
      best_in       = best_ff;
      hit_in        = hit_ff;
      q_pop         = 1'b0;
      we            = 1'b0;
      rsp_valid_in  = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty && out_free) begin
               q_pop = 1'b1;
               if (q_cmd.fetch) begin
                  slot_in  = q_slot;
                  lo_in    = '0;
                  hi_in    = q_count;
                  qt_in    = q_cmd.tstamp;
                  hit_in   = 1'b0;
                  best_in  = '0;
                  state_in = S_SRCH;
               end else begin
                  we            = q_cmd.wr;
                  rsp_valid_in  = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_value_in  = '0;
                  rsp_status_in = q_cmd.status;
               end
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid;
               state_in = S_CMP;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = hit_ff;
               rsp_value_in  = best_ff;
               rsp_status_in = hit_ff ? vkvs_pkg::ST_HIT : vkvs_pkg::ST_MISS;
               state_in      = S_IDLE;
            end
         end
         S_CMP: begin
            if (rd_t_ff <= qt_ff) begin
               hit_in  = 1'b1;
               best_in = rd_v_ff;
               lo_in   = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      qt_ff         <= qt_in;
      best_ff       <= best_in;
      hit_ff        <= hit_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // write and read the history memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem_t[addr] <= q_cmd.tstamp;
         mem_v[addr] <= q_cmd.value;
      end
      rd_t_ff <= mem_t[addr];
      rd_v_ff <= mem_v[addr];
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.result_value = rsp_value_ff;
   assign rsp_bus.status       = rsp_status_ff;

endmodule

@@ tb/sv/versioned_key_value_store_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_key_value_store_tb
// Drives store and retrieve requests into the key/value store, predicts each
// response with a behavioral copy of the key table and histories, and checks
// every response transfer field by field under random source and sink idling.
// ----------------------------------------------------------------------------
module versioned_key_value_store_tb;

   localparam int NK = vkvs_pkg::NUM_KEYS_DEF;
   localparam int NE = vkvs_pkg::ENTRIES_PER_KEY_DEF;

   typedef struct packed {
      logic        found;
      logic [31:0] value;
      logic [2:0]  status;
   } rsp_type;

   logic clock;
   logic reset;

   vkvs_req_if req_bus ();
   vkvs_rsp_if rsp_bus ();

   versioned_key_value_store u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   // predictor state
   logic [31:0] key_of   [NK];
   logic        key_used [NK];
   int          key_cnt  [NK];
   logic [31:0] hist_t   [NK][NE];
   logic [31:0] hist_v   [NK][NE];

   rsp_type pending_rsps [$];
   int   errors;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_off;
   logic [31:0] used_keys [$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int slot_lookup(logic [31:0] k);
      for (int s = 0; s < NK; s++)
         if (key_used[s] && key_of[s] == k) return s;
      return -1;
   endfunction

   function automatic rsp_type predict_rsp(logic typ, logic [31:0] k, logic [31:0] v,
                                           logic [31:0] t);
      rsp_type r;
      int   s;
      r = '0;
      s = slot_lookup(k);
      if (typ == vkvs_pkg::TYPE_STORE) begin
         if (s < 0) begin
            for (int i = 0; i < NK; i++)
               if (!key_used[i] && s < 0) s = i;
            if (s < 0) begin
               r.status = vkvs_pkg::ST_FULL;
               return r;
            end
            key_used[s] = 1'b1;
            key_of[s]   = k;
            key_cnt[s]  = 0;
         end
         if (key_cnt[s] > 0 && t <= hist_t[s][key_cnt[s]-1]) r.status = vkvs_pkg::ST_ORDER;
         else if (key_cnt[s] >= NE) r.status = vkvs_pkg::ST_FULL;
         else begin
            hist_t[s][key_cnt[s]] = t;
            hist_v[s][key_cnt[s]] = v;
            key_cnt[s]++;
            r.status = vkvs_pkg::ST_STORED;
         end
      end else begin
         r.status = vkvs_pkg::ST_MISS;
         // floor search: newest entry not after t
         if (s >= 0)
            for (int i = 0; i < key_cnt[s]; i++)
               if (hist_t[s][i] <= t) begin
                  r.found  = 1'b1;
                  r.value  = hist_v[s][i];
                  r.status = vkvs_pkg::ST_HIT;
               end
      end
      return r;
   endfunction

   // append a prediction at the tail of the queue
   function automatic void enqueue_rsp(rsp_type r);
      pending_rsps = {pending_rsps, r};
   endfunction

   // append a key to the pool of known keys
   function automatic void add_key(logic [31:0] k);
      used_keys = {used_keys, k};
   endfunction

   // send one request, predict on transfer
   task automatic send_req(logic typ, logic [31:0] k, logic [31:0] v, logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= typ;
      req_bus.req_key   <= k;
      req_bus.req_value <= v;
      req_bus.req_time  <= t;
      do @(posedge clock); while (!req_bus.ready);
      enqueue_rsp(predict_rsp(typ, k, v, t));
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // ready generation with optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off      <= hold_off - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // check each response transfer against the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response status=%0d", rsp_bus.status);
         end else begin
            exp_r = pending_rsps.pop_front();
            if (exp_r.found !== rsp_bus.found || exp_r.value !== rsp_bus.result_value ||
                exp_r.status !== rsp_bus.status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp f=%0d v=%h s=%0d got f=%0d v=%h s=%0d",
                           exp_r.found, exp_r.value, exp_r.status, rsp_bus.found,
                           rsp_bus.result_value, rsp_bus.status);
            end
         end
      end
   end

   function automatic logic [31:0] pick_key();
      if (used_keys.size() > 0 && $urandom_range(9) < 8)
         return used_keys[$urandom_range(used_keys.size() - 1)];
      return $urandom();
   endfunction

   // extremes, miss paths and ordering
   task automatic test_directed();
      send_req(vkvs_pkg::TYPE_FETCH, 32'h0, 32'h0, 32'h0);
      send_req(vkvs_pkg::TYPE_STORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      send_req(vkvs_pkg::TYPE_STORE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0);
      send_req(vkvs_pkg::TYPE_STORE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
      send_req(vkvs_pkg::TYPE_STORE, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF);
      send_req(vkvs_pkg::TYPE_FETCH, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_req(vkvs_pkg::TYPE_FETCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_req(vkvs_pkg::TYPE_FETCH, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
      send_req(vkvs_pkg::TYPE_STORE, 32'h0, 32'h0, 32'h10);
      send_req(vkvs_pkg::TYPE_FETCH, 32'h0, 32'h0, 32'hF);
      send_req(vkvs_pkg::TYPE_FETCH, 32'h0, 32'h0, 32'h10);
      send_req(vkvs_pkg::TYPE_FETCH, 32'h5, 32'h0, 32'h10);
      drain();
   endtask

   // fill one history to its limit, then the key table
   task automatic test_limits();
      for (int i = 0; i < NE + 2; i++)
         send_req(vkvs_pkg::TYPE_STORE, 32'h77, $urandom(), i * 3 + 1);
      send_req(vkvs_pkg::TYPE_STORE, 32'h77, 32'h0, 32'h1);
      for (int i = 0; i < NE + 1; i++)
         send_req(vkvs_pkg::TYPE_FETCH, 32'h77, 32'h0, i * 3 + 1);
      drain();
      for (int i = 0; i < NK; i++) send_req(vkvs_pkg::TYPE_STORE, 32'h1000 + i, i, 32'h5);
      send_req(vkvs_pkg::TYPE_FETCH, 32'h2000, 32'h0, 32'h5);
      drain();
   endtask

   // random traffic on a fresh-looking table is impossible without reset,
   // so spread sets over the known keys with rising times and random queries
   task automatic test_random(int n);
      logic [31:0] k;
      int s;
      for (int i = 0; i < n; i++) begin
         k = pick_key();
         s = slot_lookup(k);
         if ($urandom_range(1) == 0) begin
            if (s >= 0 && key_cnt[s] > 0 && $urandom_range(9) < 7)
               send_req(vkvs_pkg::TYPE_STORE, k, $urandom(),
                        hist_t[s][key_cnt[s]-1] + $urandom_range(1, 3));
            else
               send_req(vkvs_pkg::TYPE_STORE, k, $urandom(), $urandom());
         end else if (s >= 0 && key_cnt[s] > 0) begin
            send_req(vkvs_pkg::TYPE_FETCH, k, $urandom(),
                     hist_t[s][$urandom_range(key_cnt[s]-1)] + $urandom_range(0, 2) - 1);
         end else begin
            send_req(vkvs_pkg::TYPE_FETCH, k, $urandom(), $urandom());
         end
      end
   endtask

   // hold off the sink while the source keeps offering
   task automatic test_backpressure();
      hold_off = 300;
      test_random(40);
      drain();
   endtask

   initial begin
      errors        = 0;
      hold_off      = 0;
      send_idle_pct = 31;
      recv_idle_pct = 58;
      for (int s = 0; s < NK; s++) begin
         key_used[s] = 1'b0;
         key_cnt[s]  = 0;
      end
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= vkvs_pkg::TYPE_STORE;
      req_bus.req_key   <= '0;
      req_bus.req_value <= '0;
      req_bus.req_time  <= '0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int s = 0; s < NK; s++) add_key(32'h1000 + s);
      add_key(32'h77);
      add_key(32'hFFFF_FFFF);
      add_key(32'h0);
      test_directed();
      test_limits();
      test_random(500);
      drain();
      send_idle_pct = 58;
      recv_idle_pct = 31;
      test_random(500);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(500);
      drain();
      if (errors == 0 && pending_rsps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
